[rtl/hashed_l2_l3_learning_lookup_macros.svh]
// Assertion macros shared by the checker of the hashed L2/L3 learning lookup.
`ifndef HASHED_L2_L3_LEARNING_LOOKUP_MACROS_SVH
`define HASHED_L2_L3_LEARNING_LOOKUP_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, switched off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/hll_pkg.sv]
// Shared widths, constants and types of the hashed L2/L3 learning lookup.
package hll_pkg;

    localparam int MAC_W         = 48;
    localparam int IP_W          = 32;
    localparam int CNT_W         = 32;
    localparam int L2_SLOT_W     = 8;
    localparam int L3_SLOT_W     = 10;
    localparam int L3_FOLD_SHIFT = 16;

    // Table indexes of one packet, already reduced to the table depths.
    typedef struct packed {
        logic [L2_SLOT_W-1:0] l2_slot;
        logic [L3_SLOT_W-1:0] l3_slot;
    } t_slots;

endpackage

[rtl/hll_hash.sv]
// Slot hashing for the L2 and L3 tables, with reduction to the table depths.
module hll_hash
    import hll_pkg::*;
#(
    parameter int L2_DEPTH = 256,
    parameter int L3_DEPTH = 1024
) (
    input  logic [MAC_W-1:0] i_source_mac,
    input  logic [IP_W-1:0]  i_source_ip,
    output t_slots           o_slots
);

    localparam logic [16:0] L2_DIV = 17'(L2_DEPTH);
    localparam logic [16:0] L3_DIV = 17'(L3_DEPTH);

    // Remainder by restoring subtraction of shifted copies of a fixed divisor.
    // The eight steps cover any 10-bit value whenever the divisor is at least 4.
    function automatic logic [L3_SLOT_W-1:0] reduce(input logic [L3_SLOT_W-1:0] v,
                                                    input logic [16:0] d);
        logic [24:0] rem;
        logic [24:0] sub;
        rem = 25'(v);
        for (int k = 7; k >= 0; k--) begin
            sub = 25'(d) << k;
            if (rem >= sub) begin
                rem = rem - sub;
            end
        end
        return rem[L3_SLOT_W-1:0];
    endfunction

    logic [L2_SLOT_W-1:0] l2_hash;
    logic [L3_SLOT_W-1:0] l3_hash;
    logic [L3_SLOT_W-1:0] l2_red;

    assign l2_hash = i_source_mac[47:40] ^ i_source_mac[39:32]
                   ^ i_source_mac[31:24] ^ i_source_mac[23:16];
    assign l3_hash = i_source_ip[L3_SLOT_W-1:0]
                   ^ i_source_ip[L3_FOLD_SHIFT+L3_SLOT_W-1:L3_FOLD_SHIFT];

    assign l2_red          = reduce(L3_SLOT_W'(l2_hash), L2_DIV);
    assign o_slots.l2_slot = l2_red[L2_SLOT_W-1:0];
    assign o_slots.l3_slot = reduce(l3_hash, L3_DIV);

endmodule

[rtl/hll_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module hll_ram
    import hll_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Read-before-write: a read and a write of the same entry in one cycle
    // return the old contents.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/hashed_l2_l3_learning_lookup.sv]
// Top level of the hashed L2/L3 learning lookup: tables, forwarding and handshakes.
//
//   Channel  Direction  Handshake                 Payload
//   input    in         i_in_valid / o_in_stall   i_source_mac, i_source_ip, i_dest_ip
//   output   out        o_out_valid / i_out_stall o_l2_hit, o_l2_slot, o_l3_hit,
//                                                 o_l3_slot, o_l2_learned_total,
//                                                 o_l3_learned_total
//
// One header is taken per cycle when the sweep is done and the output side keeps up;
// a result passes from the input transfer through the registered table read, which
// feeds the update stage, into the output register.
// After reset both tables are swept to zero, one entry per cycle over
// max(L2_DEPTH, L3_DEPTH) entries (1024 by default), with o_in_stall held high.
// A stall on a valid output holds the output register and the update stage, and
// o_in_stall is raised in the same cycle while the update stage holds a header.
module hashed_l2_l3_learning_lookup
    import hll_pkg::*;
#(
    parameter int L2_DEPTH = 256,
    parameter int L3_DEPTH = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [MAC_W-1:0]     i_source_mac,
    input  logic [IP_W-1:0]      i_source_ip,
    input  logic [IP_W-1:0]      i_dest_ip,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic                 o_l2_hit,
    output logic [L2_SLOT_W-1:0] o_l2_slot,
    output logic                 o_l3_hit,
    output logic [L3_SLOT_W-1:0] o_l3_slot,
    output logic [CNT_W-1:0]     o_l2_learned_total,
    output logic [CNT_W-1:0]     o_l3_learned_total
);

    localparam int AW2     = $clog2(L2_DEPTH);
    localparam int AW3     = $clog2(L3_DEPTH);
    localparam int CLR_LEN = (L2_DEPTH > L3_DEPTH) ? L2_DEPTH : L3_DEPTH;
    localparam int CW      = $clog2(CLR_LEN);

    // ------------------------------------------------------------------
    // Handshake and pipeline control.
    // Stage 1 holds an accepted header while its table entries are read out;
    // it decides hit or learn and, when it advances, writes back and moves
    // into the output register.
    // ------------------------------------------------------------------
    logic in_xfer;
    logic s1_adv;

    logic r_clr_busy;
    logic [CW-1:0] r_clr_idx;

    logic r_s1_valid;
    t_slots r_s1_slots;
    logic [MAC_W-1:0] r_s1_mac;
    logic [IP_W-1:0] r_s1_dip;

    logic r_o_valid;

    assign s1_adv     = r_s1_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_clr_busy || (r_s1_valid && !s1_adv);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // Slot hashing is done on the input port so that the tables are read
    // in the same cycle as the transfer.
    t_slots in_slots;

    hll_hash #(
        .L2_DEPTH(L2_DEPTH),
        .L3_DEPTH(L3_DEPTH)
    ) u_hash (
        .i_source_mac(i_source_mac),
        .i_source_ip (i_source_ip),
        .o_slots     (in_slots)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_slots <= in_slots;
            r_s1_mac   <= i_source_mac;
            r_s1_dip   <= i_dest_ip;
        end
    end

    // ------------------------------------------------------------------
    // Clearing sweep after reset. Both tables are zeroed in parallel; the
    // shallower one simply stops being written once its last entry is done.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == CW'(CLR_LEN - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Table memories.
    // ------------------------------------------------------------------
    logic             l2_wr_en;
    logic [AW2-1:0]   l2_wr_addr;
    logic [MAC_W-1:0] l2_wr_data;
    logic [MAC_W-1:0] l2_rd_data;

    logic             l3_wr_en;
    logic [AW3-1:0]   l3_wr_addr;
    logic [IP_W-1:0]  l3_wr_data;
    logic [IP_W-1:0]  l3_rd_data;

    hll_ram #(
        .DEPTH(L2_DEPTH),
        .WIDTH(MAC_W)
    ) u_mac_ram (
        .i_clk    (i_clk),
        .i_wr_en  (l2_wr_en),
        .i_wr_addr(l2_wr_addr),
        .i_wr_data(l2_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(AW2'(in_slots.l2_slot)),
        .o_rd_data(l2_rd_data)
    );

    hll_ram #(
        .DEPTH(L3_DEPTH),
        .WIDTH(IP_W)
    ) u_route_ram (
        .i_clk    (i_clk),
        .i_wr_en  (l3_wr_en),
        .i_wr_addr(l3_wr_addr),
        .i_wr_data(l3_wr_data),
        .i_rd_en  (in_xfer),
        .i_rd_addr(AW3'(in_slots.l3_slot)),
        .o_rd_data(l3_rd_data)
    );

    // ------------------------------------------------------------------
    // Forwarding. Each table keeps a copy of its latest learn write (for L2
    // only the first MAC byte). The read of a header can coincide with the
    // write-back of the header ahead of it; the RAM then returns the old
    // word and the copy supplies the new one. A copy of an older write
    // matches whatever the RAM holds, so it is always safe on a slot match.
    // ------------------------------------------------------------------
    logic                 r_wr2_valid;
    logic [L2_SLOT_W-1:0] r_wr2_slot;
    logic [7:0]           r_wr2_byte;
    logic                 r_wr3_valid;
    logic [L3_SLOT_W-1:0] r_wr3_slot;
    logic [IP_W-1:0]      r_wr3_word;

    logic [7:0]      l2_first_byte;
    logic [IP_W-1:0] l3_word;
    logic            l2_hit;
    logic            l3_hit;

    always_comb begin
        if (r_wr2_valid && (r_wr2_slot == r_s1_slots.l2_slot)) begin
            l2_first_byte = r_wr2_byte;
        end else begin
            l2_first_byte = l2_rd_data[47:40];
        end
        if (r_wr3_valid && (r_wr3_slot == r_s1_slots.l3_slot)) begin
            l3_word = r_wr3_word;
        end else begin
            l3_word = l3_rd_data;
        end
        l2_hit = (l2_first_byte != 8'h00);
        l3_hit = (l3_word != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr2_valid <= 1'b0;
            r_wr3_valid <= 1'b0;
        end else begin
            if (s1_adv && !l2_hit) begin
                r_wr2_valid <= 1'b1;
            end
            if (s1_adv && !l3_hit) begin
                r_wr3_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && !l2_hit) begin
            r_wr2_slot <= r_s1_slots.l2_slot;
            r_wr2_byte <= r_s1_mac[47:40];
        end
        if (s1_adv && !l3_hit) begin
            r_wr3_slot <= r_s1_slots.l3_slot;
            r_wr3_word <= r_s1_dip;
        end
    end

    // Write ports: the clearing sweep owns them until it finishes, after
    // which a miss writes the learned MAC or route back.
    always_comb begin
        if (r_clr_busy) begin
            l2_wr_en   = (32'(r_clr_idx) < L2_DEPTH);
            l2_wr_addr = r_clr_idx[AW2-1:0];
            l2_wr_data = '0;
            l3_wr_en   = (32'(r_clr_idx) < L3_DEPTH);
            l3_wr_addr = r_clr_idx[AW3-1:0];
            l3_wr_data = '0;
        end else begin
            l2_wr_en   = s1_adv && !l2_hit;
            l2_wr_addr = AW2'(r_s1_slots.l2_slot);
            l2_wr_data = r_s1_mac;
            l3_wr_en   = s1_adv && !l3_hit;
            l3_wr_addr = AW3'(r_s1_slots.l3_slot);
            l3_wr_data = r_s1_dip;
        end
    end

    // ------------------------------------------------------------------
    // Learn counters, wrapping at 32 bits.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] r_l2_cnt;
    logic [CNT_W-1:0] r_l3_cnt;
    logic [CNT_W-1:0] n_l2_cnt;
    logic [CNT_W-1:0] n_l3_cnt;

    assign n_l2_cnt = r_l2_cnt + CNT_W'(!l2_hit);
    assign n_l3_cnt = r_l3_cnt + CNT_W'(!l3_hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_cnt <= '0;
            r_l3_cnt <= '0;
        end else if (s1_adv) begin
            r_l2_cnt <= n_l2_cnt;
            r_l3_cnt <= n_l3_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                 r_o_l2_hit;
    logic [L2_SLOT_W-1:0] r_o_l2_slot;
    logic                 r_o_l3_hit;
    logic [L3_SLOT_W-1:0] r_o_l3_slot;
    logic [CNT_W-1:0]     r_o_l2_cnt;
    logic [CNT_W-1:0]     r_o_l3_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (s1_adv) begin
            r_o_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_o_l2_hit  <= l2_hit;
            r_o_l2_slot <= r_s1_slots.l2_slot;
            r_o_l3_hit  <= l3_hit;
            r_o_l3_slot <= r_s1_slots.l3_slot;
            r_o_l2_cnt  <= n_l2_cnt;
            r_o_l3_cnt  <= n_l3_cnt;
        end
    end

    assign o_out_valid        = r_o_valid;
    assign o_l2_hit           = r_o_l2_hit;
    assign o_l2_slot          = r_o_l2_slot;
    assign o_l3_hit           = r_o_l3_hit;
    assign o_l3_slot          = r_o_l3_slot;
    assign o_l2_learned_total = r_o_l2_cnt;
    assign o_l3_learned_total = r_o_l3_cnt;

endmodule

[rtl/hll_checker.sv]
// Port-level checker for the hashed L2/L3 learning lookup, bound to the top level.
`include "hashed_l2_l3_learning_lookup_macros.svh"

module hll_checker
    import hll_pkg::*;
#(
    parameter int L2_DEPTH = 256,
    parameter int L3_DEPTH = 1024
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input logic                 o_l2_hit,
    input logic [L2_SLOT_W-1:0] o_l2_slot,
    input logic                 o_l3_hit,
    input logic [L3_SLOT_W-1:0] o_l3_slot,
    input logic [CNT_W-1:0]     o_l2_learned_total,
    input logic [CNT_W-1:0]     o_l3_learned_total
);

    localparam int OUT_W = 1 + L2_SLOT_W + 1 + L3_SLOT_W + 2 * CNT_W;

    // Learn totals of the last result transferred, zero after reset.
    logic [CNT_W-1:0] r_l2_prev;
    logic [CNT_W-1:0] r_l3_prev;
    logic             out_xfer;
    logic             out_held;
    logic             slots_ok;
    logic             l2_step_ok;
    logic             l3_step_ok;
    logic [OUT_W-1:0] out_word;

    assign out_xfer   = o_out_valid && !i_out_stall;
    assign out_held   = o_out_valid && i_out_stall;
    assign slots_ok   = (32'(o_l2_slot) < L2_DEPTH) && (32'(o_l3_slot) < L3_DEPTH);
    assign l2_step_ok = (o_l2_learned_total == (r_l2_prev + CNT_W'(!o_l2_hit)));
    assign l3_step_ok = (o_l3_learned_total == (r_l3_prev + CNT_W'(!o_l3_hit)));
    assign out_word   = {o_l2_hit, o_l2_slot, o_l3_hit, o_l3_slot,
                         o_l2_learned_total, o_l3_learned_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l2_prev <= '0;
            r_l3_prev <= '0;
        end else if (out_xfer) begin
            r_l2_prev <= o_l2_learned_total;
            r_l3_prev <= o_l3_learned_total;
        end
    end

    `ASSERT_IMPLY(a_slot_range, i_clk, i_rst_n, o_out_valid, slots_ok)
    `ASSERT_IMPLY(a_l2_count_step, i_clk, i_rst_n, o_out_valid, l2_step_ok)
    `ASSERT_IMPLY(a_l3_count_step, i_clk, i_rst_n, o_out_valid, l3_step_ok)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_held, o_out_valid && $stable(out_word))

endmodule

bind hashed_l2_l3_learning_lookup hll_checker #(
    .L2_DEPTH(L2_DEPTH),
    .L3_DEPTH(L3_DEPTH)
) u_hll_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_l2_hit          (o_l2_hit),
    .o_l2_slot         (o_l2_slot),
    .o_l3_hit          (o_l3_hit),
    .o_l3_slot         (o_l3_slot),
    .o_l2_learned_total(o_l2_learned_total),
    .o_l3_learned_total(o_l3_learned_total)
);

[tb/sv/tb_hashed_l2_l3_learning_lookup.sv]
`timescale 1ns / 100ps
// Self-checking testbench of the hashed L2/L3 learning lookup, with a table-mirroring scoreboard.
module tb_hashed_l2_l3_learning_lookup
    import hll_pkg::*;
();

    // The block is built at its default depths, so both hashes index the tables directly.
    localparam int L2_ENTRIES   = 256;
    localparam int L3_ENTRIES   = 1024;
    localparam int RANDOM_ITEMS = 1300;
    localparam int IDLE_PERCENT = 22;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 40000;
    localparam int RECENT_SLOTS = 32;

    // Mirrors both tables and both learn counters. Every accepted header is looked up
    // here as well, and the lookup it should produce waits in a queue until the block
    // delivers its own.
    class lookup_scoreboard #(int L2N = 256, int L3N = 1024);
        typedef struct packed {
            logic                 l2_hit;
            logic [L2_SLOT_W-1:0] l2_slot;
            logic                 l3_hit;
            logic [L3_SLOT_W-1:0] l3_slot;
            logic [CNT_W-1:0]     l2_total;
            logic [CNT_W-1:0]     l3_total;
        } t_lookup;

        logic [MAC_W-1:0] mac_copy[L2N];
        logic [IP_W-1:0]  route_copy[L3N];
        logic [CNT_W-1:0] mac_learns;
        logic [CNT_W-1:0] route_learns;
        t_lookup          awaited_lookups[$];
        int               errors;
        int               checked;
        int               l2_hits;
        int               l3_hits;

        function new();
            foreach (mac_copy[k]) mac_copy[k] = '0;
            foreach (route_copy[k]) route_copy[k] = '0;
            mac_learns   = '0;
            route_learns = '0;
            errors       = 0;
            checked      = 0;
            l2_hits      = 0;
            l3_hits      = 0;
        endfunction

        // Looks one header up in the mirrored tables and queues the lookup it gives.
        function void note_header(logic [MAC_W-1:0] mac, logic [IP_W-1:0] sip,
                                  logic [IP_W-1:0] dip);
            t_lookup         res;
            logic [7:0]      l2_hash;
            logic [IP_W-1:0] folded;
            int              l2_pos;
            int              l3_pos;
            l2_hash = mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16];
            l2_pos  = int'(l2_hash) % L2N;
            folded  = sip ^ (sip >> L3_FOLD_SHIFT);
            l3_pos  = int'(folded[9:0]) % L3N;

            // Only the first byte of the stored MAC decides a hit.
            res.l2_hit = (mac_copy[l2_pos][47:40] != 8'h00);
            if (!res.l2_hit) begin
                mac_copy[l2_pos] = mac;
                mac_learns = mac_learns + 1;
            end
            res.l3_hit = (route_copy[l3_pos] != '0);
            if (!res.l3_hit) begin
                route_copy[l3_pos] = dip;
                route_learns = route_learns + 1;
            end
            res.l2_slot  = L2_SLOT_W'(l2_pos);
            res.l3_slot  = L3_SLOT_W'(l3_pos);
            res.l2_total = mac_learns;
            res.l3_total = route_learns;
            awaited_lookups.insert(awaited_lookups.size(), res);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        // Compares one delivered lookup, field by field, with the oldest one awaited.
        task check_lookup(t_lookup got);
            t_lookup want;
            if (awaited_lookups.size() == 0) begin
                report($sformatf("lookup with nothing awaited: slots %0d/%0d",
                                 got.l2_slot, got.l3_slot));
            end else begin
                want = awaited_lookups.pop_front();
                checked++;
                if (want.l2_hit) l2_hits++;
                if (want.l3_hit) l3_hits++;
                if (got.l2_hit !== want.l2_hit)
                    report($sformatf("l2_hit %b, want %b", got.l2_hit, want.l2_hit));
                if (got.l2_slot !== want.l2_slot)
                    report($sformatf("l2_slot %0d, want %0d", got.l2_slot, want.l2_slot));
                if (got.l3_hit !== want.l3_hit)
                    report($sformatf("l3_hit %b, want %b", got.l3_hit, want.l3_hit));
                if (got.l3_slot !== want.l3_slot)
                    report($sformatf("l3_slot %0d, want %0d", got.l3_slot, want.l3_slot));
                if (got.l2_total !== want.l2_total)
                    report($sformatf("l2_learned_total %0d, want %0d",
                                     got.l2_total, want.l2_total));
                if (got.l3_total !== want.l3_total)
                    report($sformatf("l3_learned_total %0d, want %0d",
                                     got.l3_total, want.l3_total));
            end
        endtask

        function int outstanding();
            return awaited_lookups.size();
        endfunction

        task close_out();
            if (awaited_lookups.size() != 0)
                report($sformatf("%0d lookups never delivered", awaited_lookups.size()));
        endtask
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [MAC_W-1:0]     i_source_mac;
    logic [IP_W-1:0]      i_source_ip;
    logic [IP_W-1:0]      i_dest_ip;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_l2_hit;
    logic [L2_SLOT_W-1:0] o_l2_slot;
    logic                 o_l3_hit;
    logic [L3_SLOT_W-1:0] o_l3_slot;
    logic [CNT_W-1:0]     o_l2_learned_total;
    logic [CNT_W-1:0]     o_l3_learned_total;

    lookup_scoreboard #(L2_ENTRIES, L3_ENTRIES) board;

    // While this is set neither side idles, giving one long stretch at full rate.
    bit               quiet;
    int               cycles;
    logic [MAC_W-1:0] mac_pool[RECENT_SLOTS];
    logic [IP_W-1:0]  sip_pool[RECENT_SLOTS];

    hashed_l2_l3_learning_lookup #(
        .L2_DEPTH(L2_ENTRIES),
        .L3_DEPTH(L3_ENTRIES)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_source_mac       (i_source_mac),
        .i_source_ip        (i_source_ip),
        .i_dest_ip          (i_dest_ip),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_l2_hit           (o_l2_hit),
        .o_l2_slot          (o_l2_slot),
        .o_l3_hit           (o_l3_hit),
        .o_l3_slot          (o_l3_slot),
        .o_l2_learned_total (o_l2_learned_total),
        .o_l3_learned_total (o_l3_learned_total)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // The run is cut short if it goes on far longer than any correct run could,
    // the clearing sweep after reset included.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // The receiving side stalls at random, except in the quiet stretch. The stall
    // changes only at the falling edge, so each rising edge sees a settled value.
    always @(negedge i_clk) begin
        i_out_stall <= !quiet && ($urandom_range(99) < IDLE_PERCENT);
    end

    // A result transfer happens at a rising edge with valid high and stall low.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            board.check_lookup({o_l2_hit, o_l2_slot, o_l3_hit, o_l3_slot,
                                o_l2_learned_total, o_l3_learned_total});
        end
    end

    // Presents one header, called and returning at a falling edge. Idle cycles, if
    // any, come first with valid low; valid then stays high until the transfer, which
    // includes the whole clearing sweep for the first header.
    task automatic send_header(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] sip,
                               input logic [IP_W-1:0] dip);
        while (!quiet && ($urandom_range(99) < IDLE_PERCENT)) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_source_mac <= mac;
        i_source_ip  <= sip;
        i_dest_ip    <= dip;
        do @(posedge i_clk); while (o_in_stall);
        board.note_header(mac, sip, dip);
        @(negedge i_clk);
    endtask

    // Random header: most are fully random, some reuse a recent MAC or source IP so
    // that the same slots are looked up again, some carry a MAC with a zero first
    // byte (learned but never a hit) and some a zero destination (stored as empty).
    task automatic send_random_header(input int n);
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  sip;
        logic [IP_W-1:0]  dip;
        if ($urandom_range(99) < 15)
            mac = mac_pool[$urandom_range(RECENT_SLOTS-1)];
        else
            mac = {16'($urandom), 32'($urandom)};
        if ($urandom_range(7) == 0)
            mac[47:40] = 8'h00;
        if ($urandom_range(99) < 30)
            sip = sip_pool[$urandom_range(RECENT_SLOTS-1)];
        else
            sip = $urandom;
        dip = ($urandom_range(9) == 0) ? '0 : IP_W'($urandom);
        mac_pool[n % RECENT_SLOTS] = mac;
        sip_pool[n % RECENT_SLOTS] = sip;
        send_header(mac, sip, dip);
    endtask

    initial begin
        board        = new();
        cycles       = 0;
        quiet        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_source_mac = '0;
        i_source_ip  = '0;
        i_dest_ip    = '0;
        i_out_stall  = 1'b0;
        foreach (mac_pool[k]) mac_pool[k] = '0;
        foreach (sip_pool[k]) sip_pool[k] = '0;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // All zero: a zero MAC lands in L2 slot 0 and reads as empty afterwards,
        // and a zero destination leaves L3 slot 0 empty, so the repeat learns twice.
        send_header('0, '0, '0);
        send_header('0, '0, '0);
        // All ones hashes to slot 0 in both tables; the second copy hits in both.
        send_header('1, '1, '1);
        send_header('1, '1, '1);
        // A MAC with a zero first byte is learned at slot 0x70 and learned again.
        send_header(48'h00_12_34_56_789A, 32'h0001_0001, 32'h0A00_0001);
        send_header(48'h00_12_34_56_0000, 32'h0001_0001, 32'h0A00_0002);
        // A real MAC then takes slot 0x70 and the next one there hits; the low
        // sixteen MAC bits play no part in the hash.
        send_header(48'h70_00_00_00_BEEF, 32'h0000_0200, 32'h8000_0001);
        send_header(48'h70_00_00_00_0001, 32'h0000_0200, 32'h0000_0000);
        send_header(48'h00_00_00_00_FFFF, 32'h0000_0100, 32'h0000_0000);
        // L3 slot 1023 reached from both halves of the source IP; the first insert
        // is a zero destination, so the second is a miss as well.
        send_header(48'h80_00_00_00_0000, 32'h0000_03FF, 32'h0000_0000);
        send_header(48'h01_00_00_00_0000, 32'h03FF_0000, 32'hA5A5_5A5A);
        send_header(48'h80_80_00_00_0000, 32'h03FF_03FF, 32'h1234_5678);
        send_header(48'h00_00_00_01_0000, 32'h03FF_0000, 32'hFFFF_FFFF);
        send_header(48'hFF_00_FF_00_5555, 32'h8000_0000, 32'h0000_0001);
        send_header(48'h55_AA_55_AA_AAAA, 32'h5555_AAAA, 32'hAAAA_5555);
        send_header(48'h01_02_04_08_1020, 32'hFFFF_0000, 32'h7FFF_FFFF);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n >= 500) && (n < 800);
            send_random_header(n);
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (board.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        board.close_out();

        $display("Checked %0d lookups: %0d L2 hits, %0d L3 hits.",
                 board.checked, board.l2_hits, board.l3_hits);
        $display("Learned %0d MACs and %0d routes, with idling on both sides.",
                 board.mac_learns, board.route_learns);
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

[hashed_l2_l3_learning_lookup.f]
+incdir+rtl
rtl/hll_pkg.sv
rtl/hll_hash.sv
rtl/hll_ram.sv
rtl/hashed_l2_l3_learning_lookup.sv
rtl/hll_checker.sv
tb/sv/tb_hashed_l2_l3_learning_lookup.sv
